>>> hw/rtl/rgbe_scanline_rle_decoder_top_assert.svh
// Assertion macros shared by the RGBE scanline decoder RTL.
// Included by the modules that carry concurrent checks; needs no other file.
// Defining SYNTH turns every macro into an empty line.
`ifndef RGBE_SCANLINE_RLE_DECODER_TOP_ASSERT_SVH
`define RGBE_SCANLINE_RLE_DECODER_TOP_ASSERT_SVH

`ifndef SYNTH
// Clocked check that is switched off while reset is high.
`define RLE_ASSERT(name, clk_s, rst_s, prop, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);
// Clocked check that also holds across reset.
`define RLE_ASSERT_ALWAYS(name, clk_s, prop, msg) \
  name: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define RLE_ASSERT(name, clk_s, rst_s, prop, msg)
`define RLE_ASSERT_ALWAYS(name, clk_s, prop, msg)
`endif

`endif

>>> hw/rtl/rgbe_rle_pkg.sv
// Types and constants of the RGBE scanline run-length decoder.
// Used by every RTL module of the block; depends on nothing.
`timescale 1ns / 1ps

package rgbe_rle_pkg;

  // Widths of the line geometry.
  localparam int unsigned COL_W = 15;

  // Range of line widths that may use the per-component run-length format.
  localparam logic [COL_W-1:0] MIN_WIDTH = 15'd8;
  localparam logic [COL_W-1:0] MAX_WIDTH = 15'd32767;

  // Byte codes of the two formats.
  localparam logic [7:0]  HDR_MARK     = 8'd2;
  localparam logic [7:0]  LIT_CODE_MAX = 8'd128;
  localparam logic [23:0] REPEAT_MARK  = 24'h010101;

  // Growth and limit of the old-format repeat shift.
  localparam logic [4:0] SHIFT_STEP  = 5'd8;
  localparam logic [4:0] SHIFT_LIMIT = 5'd24;

  // Component planes.
  typedef logic [1:0] plane_t;
  localparam plane_t PLANE_RED = 2'd0;
  localparam plane_t PLANE_EXP = 2'd3;

  // Parser phase within a scanline.
  typedef enum logic [1:0] {
    PH_START,
    PH_HEADER,
    PH_OLD,
    PH_NEW
  } phase_t;

  // Kind of write descriptor.
  typedef enum logic [1:0] {
    KIND_LIT,
    KIND_RUN,
    KIND_PIX,
    KIND_REP
  } kind_t;

  // Status of a write descriptor.
  typedef enum logic [1:0] {
    ST_OK,
    ST_CLAMP,
    ST_TRUNC
  } status_t;

  // One input transaction.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } item_t;

  // One write descriptor.
  typedef struct packed {
    kind_t            kind;
    plane_t           plane;
    logic [COL_W-1:0] column;
    logic [COL_W-1:0] count;
    logic [31:0]      value;
    logic             line_end;
    status_t          status;
  } result_t;

endpackage

>>> hw/rtl/rgbe_rle_if.sv
// Valid/ready channel interfaces of the RGBE scanline decoder.
// Holds the byte input channel and the write descriptor channel; no dependencies.
`timescale 1ns / 1ps

interface rgbe_rle_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface rgbe_rle_desc_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  plane;
  logic [14:0] column;
  logic [14:0] count;
  logic [31:0] value;
  logic        line_end;
  logic [1:0]  status;

  modport source (
    output valid, output kind, output plane, output column, output count,
    output value, output line_end, output status, input ready
  );
  modport sink (
    input valid, input kind, input plane, input column, input count,
    input value, input line_end, input status, output ready
  );
endinterface

>>> hw/rtl/rgbe_scanline_rle_decoder_top.sv
// RGBE scanline decoder: one encoded byte per cycle unless the descriptor
// channel stalls, one write descriptor per byte at most. The descriptor for a
// byte is offered on the descriptor channel after the byte has passed the
// input register and then the result register. The rate is set by the parser,
// which updates all per-line state for one byte between the input register and
// the result register. A descriptor held by a stalled receiver
// blocks new bytes once the input register is also full. The line_width
// register is written through wr_en/wr_data, resets to 1 and should only
// change while no transaction is in flight. There is no clearing pass after
// reset. Depends on rgbe_rle_pkg, the channel interfaces, the stage modules and
// rgbe_scanline_rle_decoder_top_assert.svh.
`timescale 1ns / 1ps

module rgbe_scanline_rle_decoder_top
  import rgbe_rle_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  rgbe_rle_byte_if.sink    stream,
  rgbe_rle_desc_if.source  desc,
  input  logic             wr_en,
  input  logic [COL_W-1:0] wr_data
);

  logic [COL_W-1:0] line_width;
  logic             free;
  logic             adv;
  item_t            item;
  logic             res_vld;
  result_t          res;

  // Line width configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= COL_W'(1);
    end else if (wr_en) begin
      line_width <= wr_data;
    end
  end

  rgbe_rle_in_stage u_in_stage (
    .clk    (clk),
    .rst    (rst),
    .stream (stream),
    .free   (free),
    .adv    (adv),
    .item   (item)
  );

  rgbe_rle_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .item       (item),
    .line_width (line_width),
    .res_vld    (res_vld),
    .res        (res)
  );

  rgbe_rle_out_stage u_out_stage (
    .clk     (clk),
    .rst     (rst),
    .adv     (adv),
    .res_vld (res_vld),
    .res     (res),
    .free    (free),
    .desc    (desc)
  );

  `include "rgbe_scanline_rle_decoder_top_assert.svh"

  // A truncation descriptor always closes its line.
  `RLE_ASSERT(a_trunc_ends_line, clk, rst, (desc.valid && desc.status == ST_TRUNC) |-> desc.line_end, "truncation without line end")
  // Nothing is offered on the descriptor channel right after reset.
  `RLE_ASSERT_ALWAYS(a_reset_quiet, clk, $past(rst) |-> !desc.valid, "descriptor valid after reset")
  // A stalled descriptor stays offered and unchanged.
  `RLE_ASSERT(a_desc_hold, clk, rst, (desc.valid && !desc.ready) |=> (desc.valid && $stable(desc.value)), "stalled descriptor changed")

endmodule

>>> hw/rtl/rgbe_rle_in_stage.sv
// Input register of the RGBE scanline decoder.
// Depends on rgbe_rle_pkg and rgbe_rle_byte_if.
`timescale 1ns / 1ps

module rgbe_rle_in_stage
  import rgbe_rle_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  rgbe_rle_byte_if.sink      stream,
  input  logic               free,
  output logic               adv,
  output item_t              item
);

  logic  vld;
  item_t item_q;

  // The register takes a new transaction when it is empty or its content moves on.
  assign stream.ready = !vld || free;
  assign adv          = vld && free;
  assign item         = item_q;

  // Occupancy of the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (stream.ready) begin
      vld <= stream.valid;
    end
  end

  // Payload capture.
  always_ff @(posedge clk) begin
    if (stream.ready && stream.valid) begin
      item_q.data_byte     <= stream.data_byte;
      item_q.end_of_stream <= stream.end_of_stream;
    end
  end

endmodule

>>> hw/rtl/rgbe_rle_parser.sv
// Line parser of the RGBE scanline decoder: format choice, run and literal
// decoding, old-format pixel repeat and the per-line state registers.
// Depends on rgbe_rle_pkg and rgbe_scanline_rle_decoder_top_assert.svh.
`timescale 1ns / 1ps

module rgbe_rle_parser
  import rgbe_rle_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  item_t            item,
  input  logic [COL_W-1:0] line_width,
  output logic             res_vld,
  output result_t          res
);

  // State registers.
  phase_t           phase;
  logic [23:0]      header_bytes;
  logic [1:0]       byte_index;
  logic [31:0]      pixel_assembly;
  logic [4:0]       repeat_shift;
  logic [31:0]      previous_pixel;
  logic [COL_W-1:0] current_column;
  plane_t           current_plane;
  logic [7:0]       run_remaining;
  logic             await_run_value;

  phase_t           phase_next;
  logic [23:0]      header_bytes_next;
  logic [1:0]       byte_index_next;
  logic [31:0]      pixel_assembly_next;
  logic [4:0]       repeat_shift_next;
  logic [31:0]      previous_pixel_next;
  logic [COL_W-1:0] current_column_next;
  plane_t           current_plane_next;
  logic [7:0]       run_remaining_next;
  logic             await_run_value_next;

  // Shared datapath terms.
  logic [7:0]       b;
  logic [COL_W-1:0] w;
  logic [COL_W:0]   col_ext;
  logic [COL_W:0]   w_ext;
  logic             col_in;
  logic             lit_write;
  logic [COL_W-1:0] rem;
  logic [COL_W:0]   col_inc;
  logic             pix_reach;
  logic [31:0]      asm_word;
  logic [23:0]      hdr_word;
  logic             hdr_not_run;
  logic [31:0]      hdr_pixel;
  logic             is_repeat;
  logic [31:0]      reps;
  logic             rep_clamp;
  logic [COL_W-1:0] rep_n;
  logic [COL_W:0]   rep_sum;
  logic             rep_end;
  logic             run_clamp;
  logic [COL_W-1:0] run_n;
  logic [COL_W:0]   run_sum;
  logic             run_reach;
  logic [7:0]       rr_dec;
  logic             last_plane;
  logic             restart;
  logic             advance;

  assign b = item.data_byte;

  // A zero width behaves as a width of one.
  assign w = (line_width == '0) ? COL_W'(1) : line_width;

  // Column arithmetic, repeat scaling and clamping.
  always_comb begin
    col_ext     = {1'b0, current_column};
    w_ext       = {1'b0, w};
    col_in      = current_column <= w;
    lit_write   = current_column < w;
    rem         = w - current_column;
    col_inc     = col_ext + (COL_W+1)'(1);
    pix_reach   = col_inc >= w_ext;
    asm_word    = {pixel_assembly[23:0], b};
    hdr_word    = {header_bytes[15:0], b};
    hdr_not_run = (hdr_word[23:16] != HDR_MARK) || hdr_word[15];
    hdr_pixel   = {HDR_MARK, hdr_word};
    is_repeat   = asm_word[31:8] == REPEAT_MARK;
    case (repeat_shift[4:3])
      2'd0:    reps = {24'b0, b};
      2'd1:    reps = {16'b0, b, 8'b0};
      2'd2:    reps = {8'b0, b, 16'b0};
      default: reps = {b, 24'b0};
    endcase
    // Past the line end (width lowered mid-line) a repeat is never clamped.
    rep_clamp  = col_in && (reps > {17'b0, rem});
    rep_n      = rep_clamp ? rem : reps[COL_W-1:0];
    rep_sum    = col_ext + {1'b0, rep_n};
    rep_end    = !col_in || rep_clamp || (rep_sum >= w_ext);
    run_clamp  = col_in && ({7'b0, run_remaining} > rem);
    run_n      = run_clamp ? rem : {7'b0, run_remaining};
    run_sum    = col_ext + {1'b0, run_n};
    run_reach  = run_sum >= w_ext;
    rr_dec     = run_remaining - 8'd1;
    last_plane = current_plane == PLANE_EXP;
  end

  // Next state.
  always_comb begin
    phase_next           = phase;
    header_bytes_next    = header_bytes;
    byte_index_next      = byte_index;
    pixel_assembly_next  = pixel_assembly;
    repeat_shift_next    = repeat_shift;
    previous_pixel_next  = previous_pixel;
    current_column_next  = current_column;
    current_plane_next   = current_plane;
    run_remaining_next   = run_remaining;
    await_run_value_next = await_run_value;
    restart              = 1'b0;
    advance              = 1'b0;

    if (item.end_of_stream) begin
      restart = phase != PH_START;
    end else begin
      case (phase)
        PH_START: begin
          byte_index_next = 2'd1;
          if (w < MIN_WIDTH || w > MAX_WIDTH || b != HDR_MARK) begin
            phase_next          = PH_OLD;
            pixel_assembly_next = {24'b0, b};
          end else begin
            phase_next = PH_HEADER;
          end
        end

        PH_HEADER: begin
          header_bytes_next = hdr_word;
          if (byte_index != 2'd3) begin
            byte_index_next = byte_index + 2'd1;
          end else begin
            byte_index_next = 2'd0;
            if (hdr_not_run) begin
              // The four bytes were an ordinary first pixel.
              previous_pixel_next = hdr_pixel;
              phase_next          = PH_OLD;
              if (pix_reach) begin
                restart = 1'b1;
              end else begin
                current_column_next = col_inc[COL_W-1:0];
              end
            end else begin
              phase_next           = PH_NEW;
              current_plane_next   = PLANE_RED;
              current_column_next  = '0;
              run_remaining_next   = '0;
              await_run_value_next = 1'b0;
            end
          end
        end

        PH_OLD: begin
          pixel_assembly_next = asm_word;
          if (byte_index != 2'd3) begin
            byte_index_next = byte_index + 2'd1;
          end else begin
            byte_index_next = 2'd0;
            if (is_repeat) begin
              if (repeat_shift < SHIFT_LIMIT) begin
                repeat_shift_next = repeat_shift + SHIFT_STEP;
              end
              if (b != 8'd0) begin
                if (rep_end) begin
                  restart = 1'b1;
                end else begin
                  current_column_next = rep_sum[COL_W-1:0];
                end
              end
            end else begin
              repeat_shift_next   = '0;
              previous_pixel_next = asm_word;
              if (pix_reach) begin
                restart = 1'b1;
              end else begin
                current_column_next = col_inc[COL_W-1:0];
              end
            end
          end
        end

        default: begin
          // New-format line: run value, literal byte or a fresh code.
          if (await_run_value) begin
            await_run_value_next = 1'b0;
            run_remaining_next   = '0;
            current_column_next  = run_sum[COL_W-1:0];
            advance              = run_reach;
          end else if (run_remaining != 8'd0) begin
            run_remaining_next = rr_dec;
            if (lit_write) begin
              current_column_next = col_inc[COL_W-1:0];
            end
            advance = (rr_dec == 8'd0) && (!lit_write || pix_reach);
          end else if (b > LIT_CODE_MAX) begin
            run_remaining_next   = {1'b0, b[6:0]};
            await_run_value_next = 1'b1;
          end else begin
            run_remaining_next = b;
            advance            = (b == 8'd0) && !lit_write;
          end
          // A finished plane moves on to the next, the last one ends the line.
          if (advance) begin
            if (last_plane) begin
              restart = 1'b1;
            end else begin
              current_plane_next  = current_plane + 2'd1;
              current_column_next = '0;
            end
          end
        end
      endcase
    end

    // Every new line starts from a clean state.
    if (restart) begin
      phase_next           = PH_START;
      header_bytes_next    = '0;
      byte_index_next      = '0;
      pixel_assembly_next  = '0;
      repeat_shift_next    = '0;
      previous_pixel_next  = '0;
      current_column_next  = '0;
      current_plane_next   = PLANE_RED;
      run_remaining_next   = '0;
      await_run_value_next = 1'b0;
    end
  end

  // Write descriptor for the current transaction.
  always_comb begin
    res_vld      = 1'b0;
    res.kind     = KIND_LIT;
    res.plane    = PLANE_RED;
    res.column   = current_column;
    res.count    = '0;
    res.value    = '0;
    res.line_end = 1'b0;
    res.status   = ST_OK;

    if (item.end_of_stream) begin
      if (phase != PH_START) begin
        res_vld      = 1'b1;
        res.line_end = 1'b1;
        res.status   = ST_TRUNC;
      end
    end else begin
      case (phase)
        PH_HEADER: begin
          if (byte_index == 2'd3 && hdr_not_run) begin
            res_vld      = 1'b1;
            res.kind     = KIND_PIX;
            res.count    = COL_W'(1);
            res.value    = hdr_pixel;
            res.line_end = pix_reach;
          end
        end

        PH_OLD: begin
          if (byte_index == 2'd3) begin
            if (is_repeat) begin
              res_vld      = b != 8'd0;
              res.kind     = KIND_REP;
              res.count    = rep_n;
              res.value    = previous_pixel;
              res.line_end = rep_end;
              res.status   = rep_clamp ? ST_CLAMP : ST_OK;
            end else begin
              res_vld      = 1'b1;
              res.kind     = KIND_PIX;
              res.count    = COL_W'(1);
              res.value    = asm_word;
              res.line_end = pix_reach;
            end
          end
        end

        PH_NEW: begin
          if (await_run_value) begin
            res_vld      = 1'b1;
            res.kind     = KIND_RUN;
            res.plane    = current_plane;
            res.count    = run_n;
            res.value    = {24'b0, b};
            res.line_end = last_plane && run_reach;
            res.status   = run_clamp ? ST_CLAMP : ST_OK;
          end else if (run_remaining != 8'd0 && lit_write) begin
            res_vld      = 1'b1;
            res.plane    = current_plane;
            res.count    = COL_W'(1);
            res.value    = {24'b0, b};
            res.line_end = last_plane && pix_reach;
            res.status   = (pix_reach && rr_dec != 8'd0) ? ST_CLAMP : ST_OK;
          end
        end

        default: begin
          res_vld = 1'b0;
        end
      endcase
    end
  end

  // State update, one transaction per cycle while adv is high.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_START;
      header_bytes    <= '0;
      byte_index      <= '0;
      pixel_assembly  <= '0;
      repeat_shift    <= '0;
      previous_pixel  <= '0;
      current_column  <= '0;
      current_plane   <= PLANE_RED;
      run_remaining   <= '0;
      await_run_value <= 1'b0;
    end else if (adv) begin
      phase           <= phase_next;
      header_bytes    <= header_bytes_next;
      byte_index      <= byte_index_next;
      pixel_assembly  <= pixel_assembly_next;
      repeat_shift    <= repeat_shift_next;
      previous_pixel  <= previous_pixel_next;
      current_column  <= current_column_next;
      current_plane   <= current_plane_next;
      run_remaining   <= run_remaining_next;
      await_run_value <= await_run_value_next;
    end
  end

  `include "rgbe_scanline_rle_decoder_top_assert.svh"

  // A line always begins with cleared column, run and shift state.
  `RLE_ASSERT(a_start_clean, clk, rst, (phase == PH_START) |-> (current_column == '0 && run_remaining == '0 && !await_run_value && repeat_shift == '0), "line start state not clean")
  // Only the new format waits for a run value.
  `RLE_ASSERT(a_await_new, clk, rst, await_run_value |-> (phase == PH_NEW), "run value pending outside new format")
  // A truncation always returns the parser to line start.
  `RLE_ASSERT(a_trunc_restart, clk, rst, (adv && item.end_of_stream && phase != PH_START) |=> (phase == PH_START), "no restart after end of data")

endmodule

>>> hw/rtl/rgbe_rle_out_stage.sv
// Result register of the RGBE scanline decoder, driving the descriptor channel.
// Depends on rgbe_rle_pkg and rgbe_rle_desc_if.
`timescale 1ns / 1ps

module rgbe_rle_out_stage
  import rgbe_rle_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           res_vld,
  input  result_t        res,
  output logic           free,
  rgbe_rle_desc_if.source desc
);

  logic    vld;
  result_t res_q;

  // The register can load when empty or when its transaction leaves now.
  assign free = !vld || desc.ready;

  // Occupancy of the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (free) begin
      vld <= adv && res_vld;
    end
  end

  // Descriptor capture.
  always_ff @(posedge clk) begin
    if (free && adv && res_vld) begin
      res_q <= res;
    end
  end

  assign desc.valid    = vld;
  assign desc.kind     = res_q.kind;
  assign desc.plane    = res_q.plane;
  assign desc.column   = res_q.column;
  assign desc.count    = res_q.count;
  assign desc.value    = res_q.value;
  assign desc.line_end = res_q.line_end;
  assign desc.status   = res_q.status;

endmodule

>>> tb/rgbe_rle_write_checker.sv
// Scoreboard for the RGBE scanline decoder: predicts write descriptors from the
// accepted bytes and compares them with the descriptors leaving the block.
// Depends on rgbe_rle_pkg and the channel interfaces in rgbe_rle_if.sv.
`timescale 1ns / 1ps

module rgbe_rle_write_checker
  import rgbe_rle_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  rgbe_rle_byte_if         stream,
  rgbe_rle_desc_if         desc,
  input  logic             wr_en,
  input  logic [COL_W-1:0] wr_data,
  output int unsigned      pending_writes,
  output int unsigned      mismatch_count
);

  // Shadow of the line width register and of the per-line parser state.
  logic [COL_W-1:0] line_width_q;
  phase_t           ph;
  logic [23:0]      hdr;
  logic [1:0]       bidx;
  logic [31:0]      asm_pix;
  logic [4:0]       rshift;
  logic [31:0]      last_pix;
  logic [15:0]      col_now;
  plane_t           plane_now;
  logic [7:0]       run_left;
  logic             want_value;

  // Descriptors predicted but not yet seen at the output.
  result_t          expected_writes [$];

  bit               made;
  result_t          next_write;
  result_t          want;

  // Every line starts from a clean parser state.
  function automatic void clear_line();
    ph         = PH_START;
    hdr        = '0;
    bidx       = '0;
    asm_pix    = '0;
    rshift     = '0;
    last_pix   = '0;
    col_now    = '0;
    plane_now  = PLANE_RED;
    run_left   = '0;
    want_value = 1'b0;
  endfunction

  function automatic result_t make_write(kind_t k, plane_t p, logic [15:0] c, logic [15:0] n,
                                         logic [31:0] v, logic le, status_t st);
    result_t r;
    r.kind     = k;
    r.plane    = p;
    r.column   = c[COL_W-1:0];
    r.count    = n[COL_W-1:0];
    r.value    = v;
    r.line_end = le;
    r.status   = st;
    return r;
  endfunction

  // A single old-format pixel; it closes the line when it lands on the last column.
  task automatic place_pixel(input logic [31:0] pix, input logic [15:0] w, output result_t wr);
    logic [15:0] c;
    logic        le;
    c       = col_now;
    col_now = c + 16'd1;
    le      = (col_now >= w);
    wr      = make_write(KIND_PIX, PLANE_RED, c, 16'd1, pix, le, ST_OK);
    if (le) begin
      clear_line();
    end
  endtask

  // In the run-length format a plane ends once its columns are filled and no
  // code is still open; the exponent plane ends the line.
  task automatic next_plane(input logic [15:0] w);
    if (!want_value && run_left == '0 && col_now >= w) begin
      if (plane_now >= PLANE_EXP) begin
        clear_line();
      end else begin
        plane_now = plane_now + 2'd1;
        col_now   = '0;
      end
    end
  endtask

  // Advances the shadow parser by one byte and gives the descriptor it causes.
  task automatic decode_byte(input logic [7:0] b, input logic eos,
                             output bit got_one, output result_t wr);
    logic [15:0] w;
    logic [15:0] c;
    logic [15:0] room;
    logic [15:0] n;
    logic [63:0] reps;
    status_t     st;
    logic        le;
    w       = (line_width_q == '0) ? 16'd1 : {1'b0, line_width_q};
    got_one = 1'b0;
    wr      = '0;
    if (eos) begin
      // End of data inside a line reports truncation; at line start it is silent.
      if (ph != PH_START) begin
        wr      = make_write(KIND_LIT, PLANE_RED, col_now, 16'd0, 32'd0, 1'b1, ST_TRUNC);
        got_one = 1'b1;
        clear_line();
      end
    end else begin
      case (ph)
        PH_START: begin
          clear_line();
          bidx = 2'd1;
          if (w < {1'b0, MIN_WIDTH} || w > {1'b0, MAX_WIDTH} || b != HDR_MARK) begin
            ph      = PH_OLD;
            asm_pix = {24'd0, b};
          end else begin
            ph = PH_HEADER;
          end
        end
        PH_HEADER: begin
          hdr = {hdr[15:0], b};
          if (bidx < 2'd3) begin
            bidx = bidx + 2'd1;
          end else begin
            bidx = '0;
            // A header that is not 2,2,hi,lo with hi below 128 is the first pixel.
            if (hdr[23:16] != HDR_MARK || hdr[15]) begin
              last_pix = {HDR_MARK, hdr};
              ph       = PH_OLD;
              place_pixel(last_pix, w, wr);
              got_one  = 1'b1;
            end else begin
              ph         = PH_NEW;
              plane_now  = PLANE_RED;
              col_now    = '0;
              run_left   = '0;
              want_value = 1'b0;
            end
          end
        end
        PH_OLD: begin
          asm_pix = {asm_pix[23:0], b};
          if (bidx < 2'd3) begin
            bidx = bidx + 2'd1;
          end else begin
            bidx = '0;
            if (asm_pix[31:8] == REPEAT_MARK) begin
              // Repeat of the previous pixel; the shift grows even for a zero count.
              reps = {56'd0, asm_pix[7:0]} << rshift;
              if (rshift < SHIFT_LIMIT) begin
                rshift = rshift + SHIFT_STEP;
              end
              if (reps != '0) begin
                c    = col_now;
                room = w - c;
                st   = ST_OK;
                // Past the line end a repeat is never clamped.
                if (c <= w && reps > {48'd0, room}) begin
                  reps = {48'd0, room};
                  st   = ST_CLAMP;
                end
                col_now = c + reps[15:0];
                le      = (({48'd0, c} + reps) >= {48'd0, w});
                wr      = make_write(KIND_REP, PLANE_RED, c, reps[15:0], last_pix, le, st);
                got_one = 1'b1;
                if (le) begin
                  clear_line();
                end
              end
            end else begin
              rshift   = '0;
              last_pix = asm_pix;
              place_pixel(asm_pix, w, wr);
              got_one  = 1'b1;
            end
          end
        end
        default: begin
          if (want_value) begin
            // Value byte of a component run, clamped to the end of the line.
            want_value = 1'b0;
            n          = {8'd0, run_left};
            run_left   = '0;
            c          = col_now;
            room       = w - c;
            st         = ST_OK;
            if (n > room) begin
              n  = room;
              st = ST_CLAMP;
            end
            col_now = c + n;
            le      = (plane_now == PLANE_EXP && col_now >= w);
            wr      = make_write(KIND_RUN, plane_now, c, n, {24'd0, b}, le, st);
            got_one = 1'b1;
            next_plane(w);
          end else if (run_left != '0) begin
            // Literal byte; bytes past the end of the line are swallowed.
            run_left = run_left - 8'd1;
            c        = col_now;
            if (c < w) begin
              st      = (c + 16'd1 >= w && run_left != '0) ? ST_CLAMP : ST_OK;
              col_now = c + 16'd1;
              le      = (plane_now == PLANE_EXP && col_now >= w);
              wr      = make_write(KIND_LIT, plane_now, c, 16'd1, {24'd0, b}, le, st);
              got_one = 1'b1;
            end
            next_plane(w);
          end else begin
            // Code byte: above 128 opens a run, otherwise a literal count.
            if (b > LIT_CODE_MAX) begin
              run_left   = {1'b0, b[6:0]};
              want_value = 1'b1;
            end else begin
              run_left = b;
            end
            next_plane(w);
          end
        end
      endcase
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    mismatch_count++;
    $display("%0t ns: descriptor %s: got 0x%0h, expected 0x%0h",
             $realtime, what, got, exp_val);
  endtask

  // Predict on each accepted byte, compare on each accepted descriptor.
  always @(posedge clk) begin
    if (rst) begin
      line_width_q   = 15'd1;
      clear_line();
      expected_writes.delete();
      mismatch_count = 0;
    end else begin
      if (wr_en) begin
        line_width_q = wr_data;
      end
      if (stream.valid && stream.ready) begin
        decode_byte(stream.data_byte, stream.end_of_stream, made, next_write);
        if (made) begin
          expected_writes.push_back(next_write);
        end
      end
      if (desc.valid && desc.ready) begin
        if (expected_writes.size() == 0) begin
          report_mismatch("with none expected, value", desc.value, 32'd0);
        end else begin
          want = expected_writes.pop_front();
          if (desc.kind !== want.kind) report_mismatch("kind", desc.kind, want.kind);
          if (desc.plane !== want.plane) report_mismatch("plane", desc.plane, want.plane);
          if (desc.column !== want.column) report_mismatch("column", desc.column, want.column);
          if (desc.count !== want.count) report_mismatch("count", desc.count, want.count);
          if (desc.value !== want.value) report_mismatch("value", desc.value, want.value);
          if (desc.line_end !== want.line_end) begin
            report_mismatch("line_end", desc.line_end, want.line_end);
          end
          if (desc.status !== want.status) report_mismatch("status", desc.status, want.status);
        end
      end
    end
    pending_writes = expected_writes.size();
  end

endmodule

>>> tb/rgbe_scanline_rle_decoder_top_tb.sv
// Top of the RGBE scanline decoder testbench: clock, reset, byte stimulus,
// line width settings and the verdict. Depends on rgbe_rle_pkg, the channel
// interfaces, the decoder RTL and rgbe_rle_write_checker.
`timescale 1ns / 1ps

module rgbe_scanline_rle_decoder_top_tb;
  import rgbe_rle_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int MAX_LINE_BYTES = 150;

  logic             clk = 1'b0;
  logic             rst;
  logic             wr_en;
  logic [COL_W-1:0] wr_data;
  int unsigned      pending_writes;
  int unsigned      mismatch_count;
  int unsigned      src_idle_pct;
  int unsigned      snk_stall_pct;
  int unsigned      quiet_cycles;
  item_t            stim_q [$];
  logic [COL_W-1:0] phase_widths [8];

  rgbe_rle_byte_if byte_ch ();
  rgbe_rle_desc_if desc_ch ();

  rgbe_scanline_rle_decoder_top u_dut (
    .clk     (clk),
    .rst     (rst),
    .stream  (byte_ch),
    .desc    (desc_ch),
    .wr_en   (wr_en),
    .wr_data (wr_data)
  );

  rgbe_rle_write_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .stream         (byte_ch),
    .desc           (desc_ch),
    .wr_en          (wr_en),
    .wr_data        (wr_data),
    .pending_writes (pending_writes),
    .mismatch_count (mismatch_count)
  );

  // 4 ns clock.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Descriptor receiver stalls at random according to the current phase.
  always @(posedge clk) begin
    if (rst) begin
      desc_ch.ready <= 1'b0;
    end else begin
      desc_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Watchdog: the run ends when neither channel moves a transaction for too long.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (byte_ch.valid && byte_ch.ready) || (desc_ch.valid && desc_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Mismatches found");
    $finish;
  end

  task automatic push_byte(input logic [7:0] b);
    item_t it;
    it.data_byte     = b;
    it.end_of_stream = 1'b0;
    stim_q.push_back(it);
  endtask

  task automatic push_word(input logic [31:0] wd);
    push_byte(wd[31:24]);
    push_byte(wd[23:16]);
    push_byte(wd[15:8]);
    push_byte(wd[7:0]);
  endtask

  // End of data; the byte lane carries noise.
  task automatic push_eos();
    item_t it;
    it.data_byte     = 8'($urandom_range(255));
    it.end_of_stream = 1'b1;
    stim_q.push_back(it);
  endtask

  // Cuts the line just generated at a random point and ends the data there
  // when the line is unfinished, and now and then anyway.
  task automatic finish_line(input int first, input bit complete);
    int cut;
    if (!complete || $urandom_range(99) < 12) begin
      cut = $urandom_range(first, stim_q.size() - 1);
      while (stim_q.size() > cut) begin
        void'(stim_q.pop_back());
      end
      push_eos();
    end
  endtask

  task automatic push_noise();
    repeat ($urandom_range(1, 10)) begin
      push_byte(8'($urandom_range(255)));
    end
    push_eos();
  endtask

  // Per-component run-length line: header, then four planes of runs and literals.
  task automatic gen_rle_line(input int w);
    int first;
    int col;
    int left;
    int n;
    int pick;
    bit complete;
    first    = stim_q.size();
    complete = 1'b1;
    push_byte(HDR_MARK);
    push_byte(HDR_MARK);
    push_byte(8'($urandom_range(127)));
    push_byte(8'($urandom_range(255)));
    for (int p = 0; p < 4 && complete; p++) begin
      col = 0;
      while (col < w && complete) begin
        if (stim_q.size() - first > MAX_LINE_BYTES) begin
          complete = 1'b0;
        end else begin
          left = w - col;
          pick = $urandom_range(99);
          if (pick < 6) begin
            push_byte(8'd0);
          end else if (pick < 50) begin
            n = $urandom_range(1, (left < 127) ? left : 127);
            if ($urandom_range(9) == 0) n = $urandom_range(1, 127);
            push_byte(8'(128 + n));
            push_byte(8'($urandom_range(255)));
            col += (n < left) ? n : left;
          end else begin
            n = $urandom_range(1, (left < 8) ? left : 8);
            if ($urandom_range(9) == 0) begin
              n = left + $urandom_range(1, 4);
              if (n > 128) n = 128;
            end
            push_byte(8'(n));
            repeat (n) push_byte(8'($urandom_range(255)));
            col += (n < left) ? n : left;
          end
        end
      end
    end
    finish_line(first, complete);
  endtask

  // Old-format line of pixels and repeats; some lines open with a repeat
  // streak that drives the shift to its limit.
  task automatic gen_pixel_line(input int w);
    int first;
    int col;
    int left;
    int e;
    int pick;
    int shift;
    longint amount;
    logic [31:0] pix;
    bit complete;
    first    = stim_q.size();
    complete = 1'b1;
    col      = 0;
    shift    = 0;
    if ($urandom_range(99) < 15) begin
      repeat (3) push_word({REPEAT_MARK, 8'd0});
      shift = 24;
    end
    while (col < w && complete) begin
      if (stim_q.size() - first > MAX_LINE_BYTES) begin
        complete = 1'b0;
      end else begin
        left = w - col;
        if ($urandom_range(99) < 35) begin
          pick = $urandom_range(9);
          e = (pick == 0) ? 0 : (pick == 1) ? 255 : $urandom_range(1, 6);
          push_word({REPEAT_MARK, 8'(e)});
          amount = longint'(e) << shift;
          if (shift < 24) shift += 8;
          col += (amount < left) ? int'(amount) : left;
        end else begin
          pix = $urandom;
          if (stim_q.size() == first && w >= int'(MIN_WIDTH)) begin
            // First pixel of a line that could carry a header: often a
            // lookalike header, never a real one.
            if ($urandom_range(99) < 30) pix[31:24] = HDR_MARK;
            if (pix[31:24] == HDR_MARK && pix[23:16] == HDR_MARK) pix[15] = 1'b1;
          end
          if (pix[31:8] == REPEAT_MARK) pix[8] = ~pix[8];
          push_word(pix);
          shift = 0;
          col++;
        end
      end
    end
    finish_line(first, complete);
  endtask

  task automatic fill_random(input logic [COL_W-1:0] width, input int budget);
    int start;
    int w;
    int pick;
    start = stim_q.size();
    w = (width == '0) ? 1 : int'(width);
    while (stim_q.size() - start < budget) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        push_noise();
      end else if (w >= int'(MIN_WIDTH) && pick < 60) begin
        gen_rle_line(w);
      end else begin
        gen_pixel_line(w);
      end
    end
  endtask

  // Feeds the queued bytes, one transaction at a time, with random gaps.
  task automatic send_stream();
    item_t it;
    while (stim_q.size() != 0) begin
      it = stim_q.pop_front();
      while ($urandom_range(99) < src_idle_pct) begin
        byte_ch.valid <= 1'b0;
        @(posedge clk);
      end
      byte_ch.valid         <= 1'b1;
      byte_ch.data_byte     <= it.data_byte;
      byte_ch.end_of_stream <= it.end_of_stream;
      do @(posedge clk); while (!byte_ch.ready);
    end
    byte_ch.valid <= 1'b0;
  endtask

  // Sets the width while the block is idle, runs the queued bytes and drains.
  task automatic run_phase(input bit load_width, input logic [COL_W-1:0] width, input int mode);
    if (load_width) begin
      wr_en   <= 1'b1;
      wr_data <= width;
      @(posedge clk);
      wr_en   <= 1'b0;
    end
    src_idle_pct  = (mode == 1) ? 49 : (mode == 3) ? 8 : 0;
    snk_stall_pct = (mode == 2) ? 49 : (mode == 3) ? 8 : 0;
    send_stream();
    do @(posedge clk); while (pending_writes != 0);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    rst                   = 1'b1;
    wr_en                 = 1'b0;
    wr_data               = '0;
    byte_ch.valid         = 1'b0;
    byte_ch.data_byte     = '0;
    byte_ch.end_of_stream = 1'b0;
    src_idle_pct          = 0;
    snk_stall_pct         = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Width 1 from reset: silent end of data, an extreme pixel, a zero repeat,
    // a clamped repeat of the cleared pixel and a truncated pixel.
    push_eos();
    push_word(32'hFFFF_FFFF);
    push_word({REPEAT_MARK, 8'd0});
    push_word({REPEAT_MARK, 8'd3});
    push_byte(HDR_MARK);
    push_byte(8'd3);
    push_eos();
    run_phase(1'b0, 15'd1, 0);

    // Smallest run-length width: lookalike header with a high length byte,
    // zero literal code, run overrun, and end of data inside a plane.
    push_word({HDR_MARK, HDR_MARK, 16'h8000});
    push_eos();
    push_word({HDR_MARK, HDR_MARK, 16'h0008});
    push_byte(8'd0);
    push_byte(8'hFF);
    push_byte(8'h55);
    push_eos();
    run_phase(1'b1, MIN_WIDTH, 0);

    // Random phases over a range of widths and idling modes.
    phase_widths = '{15'd8, 15'd0, 15'd5, 15'h7FFF, 15'd16, 15'd1, 15'd12, 15'd8};
    phase_widths[6] = 15'($urandom_range(9, 40));
    foreach (phase_widths[i]) begin
      fill_random(phase_widths[i], 65);
      run_phase(1'b1, phase_widths[i], i % 4);
    end

    if (mismatch_count == 0 && pending_writes == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/rgbe_rle_pkg.sv
hw/rtl/rgbe_rle_if.sv
hw/rtl/rgbe_rle_in_stage.sv
hw/rtl/rgbe_rle_parser.sv
hw/rtl/rgbe_rle_out_stage.sv
hw/rtl/rgbe_scanline_rle_decoder_top.sv
tb/rgbe_rle_write_checker.sv
tb/rgbe_scanline_rle_decoder_top_tb.sv
